>>> src/mcrps_pkg.sv
`timescale 1ns / 1ps

package mcrps_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_SET_MODE  = 3'd1,
    CMD_REPORT    = 3'd2,
    CMD_LINK_UP   = 3'd3,
    CMD_LINK_DOWN = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_SEND      = 2'd0,
    ACT_POLL      = 2'd1,
    ACT_CONFIRMED = 2'd2,
    ACT_REFUSED   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_POLL_GAP      = 2'd1,
    REG_MAX_TRIES     = 2'd2
  } reg_idx_t;

  localparam int CfgWidth      = 16;
  localparam int CfgAddrWidth  = 2;
  localparam int InDataWidth   = 40;
  localparam int OutDataWidth  = 24;
  localparam int QDepth        = 4;
  localparam int QPtrWidth     = $clog2(QDepth);
  localparam int QCntWidth     = $clog2(QDepth + 1);
  localparam int DlOffWidth    = 18;

  localparam logic [15:0] PollIntervalReset = 16'd500;
  localparam logic [9:0]  PollGapReset      = 10'd20;
  localparam logic [3:0]  MaxTriesReset     = 4'd3;
  localparam logic [DlOffWidth-1:0] DeadlineMargin = DlOffWidth'(200);

  typedef struct packed {
    action_t    action;
    logic [7:0] mode;
    logic [3:0] tries;
    logic [7:0] rep_mode;
    logic       rep_vld;
    logic       last;
  } result_t;

endpackage

>>> src/mode_confirm_retry_poll_scheduler_top.sv
`timescale 1ns / 1ps

// The first result word of an input word passes through an input register and a four-entry
// result queue before it is offered.
// Throughput: one input word per cycle; the input stalls only while the queue holds more
// than two words, which a run of two-result input words or a stalled output brings about.
// Reset: rst_n is synchronous and active low; it clears the input valid flag, the scheduler
// state and the queue pointers and count, and loads the configuration defaults.
module mode_confirm_retry_poll_scheduler_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mcrps_pkg::CfgAddrWidth-1:0]   cfg_addr,
  input  logic [mcrps_pkg::CfgWidth-1:0]       cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // now_ms [31:0], mode_value [39:32]
  input  logic [mcrps_pkg::InDataWidth-1:0]    in_tdata,
  // cmd [2:0]
  input  logic [2:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // mode_out [7:0], tries_out [11:8], last_reported_mode [19:12],
  // last_reported_valid [20], zero [23:21]
  output logic [mcrps_pkg::OutDataWidth-1:0]   out_tdata,
  // action [1:0]
  output logic [1:0]                           out_tuser,
  output logic                                 out_tlast
);
  import mcrps_pkg::*;

  logic [15:0]           poll_int_r;
  logic [9:0]            gap_r;
  logic [3:0]            max_tries_r;
  logic [DlOffWidth-1:0] dl_off_r;

  logic        s1_v_r, s1_v_nxt;
  logic [2:0]  s1_cmd_r;
  logic [31:0] s1_now_r;
  logic [7:0]  s1_mv_r;

  logic        link_up_r, link_up_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  want_r, want_nxt;
  logic [3:0]  send_cnt_r, send_cnt_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [31:0] hold_r, hold_nxt;
  logic [31:0] lpoll_r, lpoll_nxt;
  logic [7:0]  rep_mode_r, rep_mode_nxt;
  logic        rep_vld_r, rep_vld_nxt;

  result_t              q_r [QDepth];
  logic [QPtrWidth-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCntWidth-1:0] cnt_r;

  result_t     res_a, res_b;
  logic [1:0]  n_res;
  logic        fire, in_acc, pop;
  logic [31:0] dl_diff, hold_diff, poll_diff;
  logic        hold_ok;

  function automatic result_t make_res(action_t act, logic [7:0] md, logic [3:0] tr,
                                       logic [7:0] rm, logic rv);
    result_t r;
    r.action   = act;
    r.mode     = md;
    r.tries    = tr;
    r.rep_mode = rm;
    r.rep_vld  = rv;
    r.last     = 1'b0;
    return r;
  endfunction

  assign fire      = s1_v_r && (cnt_r <= QCntWidth'(QDepth - 2));
  assign in_tready = !s1_v_r || fire;
  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  assign dl_diff   = s1_now_r - dl_r;
  assign hold_diff = s1_now_r - hold_r;
  assign poll_diff = s1_now_r - lpoll_r;

  always_comb begin
    link_up_nxt  = link_up_r;
    pend_nxt     = pend_r;
    want_nxt     = want_r;
    send_cnt_nxt = send_cnt_r;
    dl_nxt       = dl_r;
    hold_nxt     = hold_r;
    lpoll_nxt    = lpoll_r;
    rep_mode_nxt = rep_mode_r;
    rep_vld_nxt  = rep_vld_r;
    res_a        = make_res(ACT_POLL, 8'd0, 4'd0, 8'd0, 1'b0);
    res_b        = res_a;
    n_res        = 2'd0;
    hold_ok      = !hold_diff[31];
    unique case (s1_cmd_r)
      CMD_LINK_UP: begin
        if (!link_up_r) begin
          link_up_nxt  = 1'b1;
          lpoll_nxt    = 32'd0;
          hold_nxt     = s1_now_r;
          pend_nxt     = 1'b0;
          send_cnt_nxt = 4'd0;
          rep_vld_nxt  = 1'b0;
        end
      end
      CMD_LINK_DOWN: begin
        link_up_nxt  = 1'b0;
        pend_nxt     = 1'b0;
        send_cnt_nxt = 4'd0;
        rep_vld_nxt  = 1'b0;
      end
      CMD_SET_MODE: begin
        if (link_up_r) begin
          want_nxt     = s1_mv_r;
          send_cnt_nxt = 4'd1;
          pend_nxt     = 1'b1;
          dl_nxt       = s1_now_r + 32'(dl_off_r);
          hold_nxt     = s1_now_r + 32'(gap_r);
          res_a        = make_res(ACT_SEND, s1_mv_r, 4'd1, rep_mode_r, rep_vld_r);
          n_res        = 2'd1;
        end
      end
      CMD_REPORT: begin
        if (link_up_r) begin
          rep_mode_nxt = s1_mv_r;
          rep_vld_nxt  = 1'b1;
          if (pend_r && s1_mv_r == want_r) begin
            res_a        = make_res(ACT_CONFIRMED, want_r, send_cnt_r, s1_mv_r, 1'b1);
            n_res        = 2'd1;
            pend_nxt     = 1'b0;
            send_cnt_nxt = 4'd0;
          end
        end
      end
      CMD_TICK: begin
        if (link_up_r) begin
          if (pend_r && !dl_diff[31]) begin
            if (send_cnt_r >= max_tries_r) begin
              res_a        = make_res(ACT_REFUSED, want_r, send_cnt_r, rep_mode_r, rep_vld_r);
              pend_nxt     = 1'b0;
              send_cnt_nxt = 4'd0;
            end else begin
              send_cnt_nxt = send_cnt_r + 4'd1;
              dl_nxt       = s1_now_r + 32'(dl_off_r);
              hold_nxt     = s1_now_r + 32'(gap_r);
              hold_ok      = (gap_r == 10'd0);
              res_a        = make_res(ACT_SEND, want_r, send_cnt_nxt, rep_mode_r, rep_vld_r);
            end
            n_res = 2'd1;
          end
          if (poll_diff >= 32'(poll_int_r) && hold_ok) begin
            lpoll_nxt = s1_now_r;
            if (n_res == 2'd0) begin
              res_a = make_res(ACT_POLL, 8'd0, send_cnt_nxt, rep_mode_r, rep_vld_r);
            end else begin
              res_b = make_res(ACT_POLL, 8'd0, send_cnt_nxt, rep_mode_r, rep_vld_r);
            end
            n_res = n_res + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
    res_a.last = (n_res == 2'd1);
    res_b.last = 1'b1;
  end

  always_comb begin
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (fire) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_int_r  <= PollIntervalReset;
      gap_r       <= PollGapReset;
      max_tries_r <= MaxTriesReset;
      dl_off_r    <= DlOffWidth'({PollIntervalReset, 1'b0}) + DeadlineMargin;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_POLL_INTERVAL: begin
          poll_int_r <= cfg_wdata;
          dl_off_r   <= DlOffWidth'({cfg_wdata, 1'b0}) + DeadlineMargin;
        end
        REG_POLL_GAP:  gap_r       <= cfg_wdata[9:0];
        REG_MAX_TRIES: max_tries_r <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r <= in_tuser;
      s1_now_r <= in_tdata[31:0];
      s1_mv_r  <= in_tdata[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_up_r  <= 1'b0;
      pend_r     <= 1'b0;
      want_r     <= 8'd0;
      send_cnt_r <= 4'd0;
      dl_r       <= 32'd0;
      hold_r     <= 32'd0;
      lpoll_r    <= 32'd0;
      rep_mode_r <= 8'd0;
      rep_vld_r  <= 1'b0;
    end else if (fire) begin
      link_up_r  <= link_up_nxt;
      pend_r     <= pend_nxt;
      want_r     <= want_nxt;
      send_cnt_r <= send_cnt_nxt;
      dl_r       <= dl_nxt;
      hold_r     <= hold_nxt;
      lpoll_r    <= lpoll_nxt;
      rep_mode_r <= rep_mode_nxt;
      rep_vld_r  <= rep_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && n_res != 2'd0) begin
      q_r[wr_ptr_r] <= res_a;
    end
    if (fire && n_res == 2'd2) begin
      q_r[wr_ptr_r + QPtrWidth'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (fire) begin
        wr_ptr_r <= wr_ptr_r + QPtrWidth'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPtrWidth'(1);
      end
      cnt_r <= cnt_r + (fire ? QCntWidth'(n_res) : QCntWidth'(0)) - QCntWidth'(pop);
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = q_r[rd_ptr_r].action;
  assign out_tlast  = q_r[rd_ptr_r].last;
  assign out_tdata  = {3'd0, q_r[rd_ptr_r].rep_vld, q_r[rd_ptr_r].rep_mode,
                       q_r[rd_ptr_r].tries, q_r[rd_ptr_r].mode};

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCntWidth'(QDepth))
    else $error("result queue overflow");

  a_pending_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> link_up_r)
    else $error("mode pending while link is down");

  a_pending_count: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (send_cnt_r != 4'd0))
    else $error("mode pending with zero send count");

  a_link_down: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_cmd_r == CMD_LINK_DOWN) |=> (!link_up_r && !pend_r && !rep_vld_r))
    else $error("link down did not clear state");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted word not held in input stage");
`endif

endmodule

>>> tb/sv/mode_confirm_retry_poll_scheduler_top_test.sv
`timescale 1ns / 1ps

module mode_confirm_retry_poll_scheduler_top_test;
  import mcrps_pkg::*;

  localparam int IdlePct = 29;
  localparam int StallLimit = 2000;
  localparam int SettleCycles = 6;
  localparam int MaxPrinted = 40;
  localparam int NumPhases = 6;
  localparam int WordsPerPhase = 140;
  localparam logic [31:0] DeadlineMarginMs = 32'd200;
  localparam logic [2:0] CmdUnusedLo = 3'd5;
  localparam logic [2:0] CmdUnusedHi = 3'd7;
  localparam result_t NoWord = '0;

  localparam logic [15:0] PhaseIvl [NumPhases] =
    '{16'd500, 16'd1, 16'd65535, 16'd0, 16'd120, 16'd700};
  localparam logic [9:0] PhaseGap [NumPhases] =
    '{10'd20, 10'd0, 10'd1000, 10'd0, 10'd0, 10'd999};
  localparam logic [3:0] PhaseTries [NumPhases] =
    '{4'd3, 4'd1, 4'd15, 4'd0, 4'd2, 4'd15};

  typedef struct {
    logic        setup;
    logic [15:0] ivl;
    logic [9:0]  gap;
    logic [3:0]  tries;
    logic [2:0]  cmd;
    logic [31:0] now;
    logic [7:0]  mv;
    logic        typed;
    int          nres;
    result_t     r0;
    result_t     r1;
  } script_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CfgAddrWidth-1:0]   cfg_addr = '0;
  logic [CfgWidth-1:0]       cfg_wdata = '0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [InDataWidth-1:0]    in_tdata = '0;
  logic [2:0]                in_tuser = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OutDataWidth-1:0]   out_tdata;
  logic [1:0]                out_tuser;
  logic                      out_tlast;

  logic [15:0] poll_ivl = 16'd500;
  logic [9:0]  poll_gap = 10'd20;
  logic [3:0]  max_tries = 4'd3;

  logic        link_on = 1'b0;
  logic        mode_wait = 1'b0;
  logic [7:0]  want_mode = '0;
  logic [3:0]  sends = '0;
  logic [31:0] confirm_by = '0;
  logic [31:0] hold_until = '0;
  logic [31:0] last_poll = '0;
  logic [7:0]  seen_mode = '0;
  logic        seen_vld = 1'b0;

  result_t     action_q [$];
  script_row_t script [$];
  int          errors = 0;
  int          stall = 0;
  bit          calm = 1'b0;
  logic [31:0] wall = '0;

  mode_confirm_retry_poll_scheduler_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit reached(logic [31:0] t, logic [31:0] mark);
    logic [31:0] d;
    d = t - mark;
    return !d[31];
  endfunction

  function automatic result_t word_of(action_t a, logic [7:0] m, logic [3:0] t,
                                      logic [7:0] rm, logic rv, logic last);
    result_t w;
    w.action = a;
    w.mode = m;
    w.tries = t;
    w.rep_mode = rm;
    w.rep_vld = rv;
    w.last = last;
    return w;
  endfunction

  function automatic result_t status_word(action_t a, logic [7:0] m, logic [3:0] t);
    return word_of(a, m, t, seen_mode, seen_vld, 1'b0);
  endfunction

  function automatic script_row_t ev(logic [2:0] cmd, logic [31:0] now, logic [7:0] mv);
    script_row_t r;
    r.setup = 1'b0;
    r.ivl = '0;
    r.gap = '0;
    r.tries = '0;
    r.cmd = cmd;
    r.now = now;
    r.mv = mv;
    r.typed = 1'b0;
    r.nres = 0;
    r.r0 = NoWord;
    r.r1 = NoWord;
    return r;
  endfunction

  function automatic script_row_t evx(logic [2:0] cmd, logic [31:0] now, logic [7:0] mv,
                                     int nres, result_t r0, result_t r1);
    script_row_t r;
    r = ev(cmd, now, mv);
    r.typed = 1'b1;
    r.nres = nres;
    r.r0 = r0;
    r.r1 = r1;
    return r;
  endfunction

  function automatic script_row_t setup_row(logic [15:0] ivl, logic [9:0] gap,
                                           logic [3:0] tries);
    script_row_t r;
    r = ev(CMD_TICK, '0, '0);
    r.setup = 1'b1;
    r.ivl = ivl;
    r.gap = gap;
    r.tries = tries;
    return r;
  endfunction

  task automatic add_row(script_row_t r);
    script = {script, r};
  endtask

  task automatic queue_word(result_t w);
    action_q = {action_q, w};
  endtask

  task automatic arm_deadline(logic [31:0] t);
    confirm_by = t + {15'd0, poll_ivl, 1'b0} + DeadlineMarginMs;
    hold_until = t + {22'd0, poll_gap};
  endtask

  task automatic advance_scheduler(input logic [2:0] cmd, input logic [31:0] now,
                                   input logic [7:0] mv, output int n,
                                   output result_t r0, output result_t r1);
    result_t w [2];
    n = 0;
    w[0] = NoWord;
    w[1] = NoWord;
    if (cmd == CMD_LINK_UP) begin
      if (!link_on) begin
        link_on = 1'b1;
        last_poll = '0;
        hold_until = now;
        mode_wait = 1'b0;
        sends = '0;
        seen_vld = 1'b0;
      end
    end else if (cmd == CMD_LINK_DOWN) begin
      link_on = 1'b0;
      mode_wait = 1'b0;
      sends = '0;
      seen_vld = 1'b0;
    end else if (cmd < CMD_LINK_UP && link_on) begin
      if (cmd == CMD_SET_MODE) begin
        want_mode = mv;
        sends = 4'd1;
        mode_wait = 1'b1;
        arm_deadline(now);
        w[n] = status_word(ACT_SEND, want_mode, sends);
        n++;
      end else if (cmd == CMD_REPORT) begin
        seen_mode = mv;
        seen_vld = 1'b1;
        if (mode_wait && mv == want_mode) begin
          w[n] = status_word(ACT_CONFIRMED, want_mode, sends);
          n++;
          mode_wait = 1'b0;
          sends = '0;
        end
      end else begin
        if (mode_wait && reached(now, confirm_by)) begin
          if (sends >= max_tries) begin
            w[n] = status_word(ACT_REFUSED, want_mode, sends);
            n++;
            mode_wait = 1'b0;
            sends = '0;
          end else begin
            sends = sends + 4'd1;
            arm_deadline(now);
            w[n] = status_word(ACT_SEND, want_mode, sends);
            n++;
          end
        end
        if (now - last_poll >= {16'd0, poll_ivl} && reached(now, hold_until)) begin
          last_poll = now;
          w[n] = status_word(ACT_POLL, 8'd0, sends);
          n++;
        end
      end
    end
    if (n > 0) w[n-1].last = 1'b1;
    r0 = w[0];
    r1 = w[1];
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MaxPrinted) begin
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    errors++;
  endtask

  task automatic offer(logic [2:0] cmd, logic [31:0] now, logic [7:0] mv);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {mv, now};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic play(logic [2:0] cmd, logic [31:0] now, logic [7:0] mv,
                      logic typed, int tn, result_t t0, result_t t1);
    int n;
    result_t p0;
    result_t p1;
    offer(cmd, now, mv);
    advance_scheduler(cmd, now, mv, n, p0, p1);
    if (typed) begin
      n = tn;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) queue_word(p0);
    if (n > 1) queue_word(p1);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (action_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_settings(logic [15:0] ivl, logic [9:0] gap, logic [3:0] tries);
    settle();
    cfg_we <= 1'b1;
    cfg_addr <= REG_POLL_INTERVAL;
    cfg_wdata <= ivl;
    @(posedge clk);
    poll_ivl = ivl;
    cfg_addr <= REG_POLL_GAP;
    cfg_wdata <= CfgWidth'(gap);
    @(posedge clk);
    poll_gap = gap;
    cfg_addr <= REG_MAX_TRIES;
    cfg_wdata <= CfgWidth'(tries);
    @(posedge clk);
    max_tries = tries;
    cfg_we <= 1'b0;
  endtask

  task automatic roam(int goal);
    int done;
    int pick;
    int span;
    logic [2:0] cmd;
    logic [7:0] mv;
    logic [31:0] at;
    logic [31:0] target;
    done = 0;
    span = 2 * int'(poll_ivl) + int'(poll_gap) + 200;
    while (done < goal) begin
      pick = $urandom_range(99);
      mv = 8'($urandom_range(255));
      at = wall;
      if (!link_on && pick < 85) begin
        cmd = CMD_LINK_UP;
      end else if (pick < 46) begin
        cmd = CMD_TICK;
        wall = wall + 32'($urandom_range(span / 3));
        at = wall;
      end else if (pick < 58) begin
        cmd = CMD_SET_MODE;
      end else if (pick < 78) begin
        cmd = CMD_REPORT;
        if ($urandom_range(1)) mv = want_mode;
      end else if (pick < 82) begin
        cmd = CMD_LINK_UP;
      end else if (pick < 86) begin
        cmd = CMD_LINK_DOWN;
      end else if (pick < 89) begin
        cmd = 3'($urandom_range(CmdUnusedHi, CmdUnusedLo));
      end else if (pick < 93) begin
        cmd = CMD_TICK;
        at = $urandom;
      end else begin
        cmd = CMD_TICK;
        target = mode_wait ? confirm_by : hold_until;
        at = target - 32'($urandom_range(1));
        if (reached(at, wall)) wall = at;
      end
      if (cmd == CMD_LINK_DOWN || (cmd == CMD_LINK_UP && !link_on) ||
          (cmd < CMD_LINK_UP && link_on)) begin
        done++;
      end
      play(cmd, at, mv, 1'b0, 0, NoWord, NoWord);
    end
  endtask

  always @(posedge clk) begin : check_words
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (action_q.size() == 0) begin
        report_mismatch("unexpected word", {8'd0, out_tdata}, '0);
      end else begin
        want = action_q.pop_front();
        if (out_tuser != want.action) begin
          report_mismatch("action", 32'(out_tuser), 32'(want.action));
        end
        if (out_tdata[7:0] != want.mode) begin
          report_mismatch("mode", 32'(out_tdata[7:0]), 32'(want.mode));
        end
        if (out_tdata[11:8] != want.tries) begin
          report_mismatch("tries", 32'(out_tdata[11:8]), 32'(want.tries));
        end
        if (out_tdata[19:12] != want.rep_mode) begin
          report_mismatch("reported mode", 32'(out_tdata[19:12]), 32'(want.rep_mode));
        end
        if (out_tdata[20] != want.rep_vld) begin
          report_mismatch("reported valid", 32'(out_tdata[20]), 32'(want.rep_vld));
        end
        if (out_tdata[23:21] != 3'd0) begin
          report_mismatch("pad bits", 32'(out_tdata[23:21]), '0);
        end
        if (out_tlast != want.last) begin
          report_mismatch("last", 32'(out_tlast), 32'(want.last));
        end
      end
    end
    out_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall <= 0;
    end else begin
      stall <= stall + 1;
    end
    if (stall >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    int ph;
    script_row_t row;

    add_row(evx(CMD_TICK, 32'd0, 8'd0, 0, NoWord, NoWord));
    add_row(evx(CMD_SET_MODE, 32'd10, 8'h12, 0, NoWord, NoWord));
    add_row(evx(CmdUnusedHi, 32'd20, 8'hFF, 0, NoWord, NoWord));
    add_row(evx(CMD_LINK_UP, 32'd1000, 8'd0, 0, NoWord, NoWord));
    add_row(evx(CMD_LINK_UP, 32'd2000, 8'd0, 0, NoWord, NoWord));
    add_row(evx(CMD_TICK, 32'd1000, 8'd0, 1,
                word_of(ACT_POLL, 8'd0, 4'd0, 8'd0, 1'b0, 1'b1), NoWord));
    add_row(evx(CMD_REPORT, 32'd1010, 8'h55, 0, NoWord, NoWord));
    add_row(evx(CMD_SET_MODE, 32'd1100, 8'hFF, 1,
                word_of(ACT_SEND, 8'hFF, 4'd1, 8'h55, 1'b1, 1'b1), NoWord));
    add_row(evx(CMD_TICK, 32'd1510, 8'd0, 1,
                word_of(ACT_POLL, 8'd0, 4'd1, 8'h55, 1'b1, 1'b1), NoWord));
    add_row(ev(CMD_REPORT, 32'd1600, 8'h00));
    add_row(ev(CMD_TICK, 32'd2300, 8'd0));
    add_row(ev(CMD_TICK, 32'd3500, 8'd0));
    add_row(ev(CMD_TICK, 32'd4700, 8'd0));
    add_row(evx(CMD_SET_MODE, 32'd5000, 8'h00, 1,
                word_of(ACT_SEND, 8'h00, 4'd1, 8'h00, 1'b1, 1'b1), NoWord));
    add_row(evx(CMD_SET_MODE, 32'd5005, 8'hAA, 1,
                word_of(ACT_SEND, 8'hAA, 4'd1, 8'h00, 1'b1, 1'b1), NoWord));
    add_row(evx(CMD_REPORT, 32'd5010, 8'hAA, 1,
                word_of(ACT_CONFIRMED, 8'hAA, 4'd1, 8'hAA, 1'b1, 1'b1), NoWord));
    add_row(evx(CMD_LINK_DOWN, 32'd5020, 8'd0, 0, NoWord, NoWord));
    add_row(evx(CMD_LINK_UP, 32'hFFFF_FF00, 8'd0, 0, NoWord, NoWord));
    add_row(evx(CMD_SET_MODE, 32'hFFFF_FF00, 8'h01, 1,
                word_of(ACT_SEND, 8'h01, 4'd1, 8'hAA, 1'b0, 1'b1), NoWord));
    add_row(ev(CMD_TICK, 32'hFFFF_FF10, 8'd0));
    add_row(ev(CMD_TICK, 32'h0000_03B0, 8'd0));
    add_row(setup_row(16'd0, 10'd0, 4'd0));
    add_row(ev(CMD_SET_MODE, 32'h0000_0900, 8'h80));
    add_row(ev(CMD_TICK, 32'h0000_09C8, 8'd0));
    add_row(ev(CMD_TICK, 32'h0000_09C8, 8'd0));
    add_row(setup_row(16'd0, 10'd0, 4'd2));
    add_row(ev(CMD_SET_MODE, 32'h0000_0A00, 8'h7F));
    add_row(ev(CMD_TICK, 32'h0000_0AC8, 8'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < script.size(); k++) begin
      row = script[k];
      if (row.setup) begin
        load_settings(row.ivl, row.gap, row.tries);
      end else begin
        play(row.cmd, row.now, row.mv, row.typed, row.nres, row.r0, row.r1);
      end
    end

    for (ph = 0; ph < NumPhases; ph++) begin
      calm = 1'b0;
      load_settings(PhaseIvl[ph], PhaseGap[ph], PhaseTries[ph]);
      calm = (ph == 2);
      wall = ph[0] ? 32'hFFFF_FFFF - 32'($urandom_range(5000)) : $urandom;
      roam(WordsPerPhase);
    end
    calm = 1'b0;

    settle();
    if (errors == 0 && action_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
